// File: hw/rtl/ias_pkg.sv
// ias_pkg: shared widths, defaults and the link type of the insertion sorter.
// No dependencies; used by ias_cell, integer_array_sorter_top and the testbench.
package ias_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_COUNT_DEF = 64;

  // One value moving along the cell row, or held in a cell.
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] value;
  } link_t;

endpackage

// File: hw/rtl/ias_cell.sv
// ias_cell: one cell of the insertion chain; keeps the smaller value, forwards the larger.
// Depends on ias_pkg (link_t, DATA_W).
module ias_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift_en,   // unload: take the right neighbor's held value
  input  ias_pkg::link_t cand_in,    // candidate from the left neighbor
  input  ias_pkg::link_t next_held,  // held value of the right neighbor
  output ias_pkg::link_t cand_out,   // candidate to the right neighbor
  output ias_pkg::link_t held        // this cell's value
);

  ias_pkg::link_t held_next;
  ias_pkg::link_t fwd_next;
  logic           cand_less;

  assign cand_less = $signed(cand_in.value) < $signed(held.value);

  always_comb begin
    held_next      = held;
    fwd_next.valid = 1'b0;
    fwd_next.value = cand_in.value;
    if (shift_en) begin
      held_next = next_held;
    end else if (cand_in.valid) begin
      if (!held.valid) begin
        held_next = cand_in;
      end else if (cand_less) begin
        held_next.value = cand_in.value;
        fwd_next.valid  = 1'b1;
        fwd_next.value  = held.value;
      end else begin
        fwd_next.valid  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held.valid     <= 1'b0;
      cand_out.valid <= 1'b0;
    end else begin
      held.valid     <= held_next.valid;
      cand_out.valid <= fwd_next.valid;
    end
    held.value     <= held_next.value;
    cand_out.value <= fwd_next.value;
  end

endmodule

// File: hw/rtl/integer_array_sorter_top.sv
// integer_array_sorter_top: block sorter built as a systolic insertion chain of ias_cell.
// Depends on ias_pkg and ias_cell.
//
// Channel   | Handshake                 | Payload
// ----------+---------------------------+----------------------------------
// item      | item_valid / item_ready   | value[31:0] signed, last
// result    | result_valid/result_ready | sorted_value[31:0] signed,
//           |                           | final_res, overflow
//
// Load: one item transfer per cycle; each value enters cell 0 and ripples right, one
// cell per cycle, every cell keeping the smaller of what it holds and what arrives.
// After the last item the chain drains, a wait set by the chain length, then unloads
// one sorted value per cycle by shifting the row left through an output register.
// item_ready is low during drain and unload. A stalled result only holds the shift.
// Reset (rst, synchronous) empties every cell; no clearing pass is needed.
module integer_array_sorter_top #(
  parameter int MAX_COUNT = ias_pkg::MAX_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic signed [ias_pkg::DATA_W-1:0] value,
  input  logic                              last,
  output logic                              result_valid,
  input  logic                              result_ready,
  output logic signed [ias_pkg::DATA_W-1:0] sorted_value,
  output logic                              final_res,
  output logic                              overflow
);

  localparam int CNT_W = $clog2(MAX_COUNT + 1);

  localparam logic [1:0] ST_LOAD   = 2'd0;
  localparam logic [1:0] ST_DRAIN  = 2'd1;
  localparam logic [1:0] ST_UNLOAD = 2'd2;

  logic [1:0]       state;
  logic [CNT_W-1:0] count;   // stored values; counts down as they are unloaded
  logic [CNT_W-1:0] timer;   // drain wait
  logic             ovf;     // a value of this block was dropped

  ias_pkg::link_t   inj;     // value waiting to enter cell 0
  ias_pkg::link_t   cand   [MAX_COUNT+1];
  ias_pkg::link_t   stored [MAX_COUNT+1];

  logic             item_xfer;
  logic             has_room;
  logic             emit;

  assign item_ready = (state == ST_LOAD);
  assign item_xfer  = item_valid && item_ready;
  assign has_room   = (count < CNT_W'(MAX_COUNT));
  assign emit       = (state == ST_UNLOAD) && (!result_valid || result_ready);

  // Chain ends: injection on the left, an empty slot shifts in on the right.
  assign cand[0]                = inj;
  assign stored[MAX_COUNT]      = '0;

  for (genvar i = 0; i < MAX_COUNT; i++) begin : g_cell
    ias_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (emit),
      .cand_in   (cand[i]),
      .next_held (stored[i+1]),
      .cand_out  (cand[i+1]),
      .held      (stored[i])
    );
  end

  // Injection register: first MAX_COUNT values of a block enter, the rest drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      inj.valid <= 1'b0;
    end else begin
      inj.valid <= item_xfer && has_room;
    end
    inj.value <= value;
  end

  // Sequencer: load, drain, unload.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      timer <= '0;
      ovf   <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (item_xfer) begin
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (last) begin
              state <= ST_DRAIN;
              timer <= CNT_W'(MAX_COUNT);
            end
          end
        end
        ST_DRAIN: begin
          if (timer == '0) begin
            state <= ST_UNLOAD;
          end else begin
            timer <= timer - CNT_W'(1);
          end
        end
        ST_UNLOAD: begin
          if (emit) begin
            count <= count - CNT_W'(1);
            if (count == CNT_W'(1)) begin
              state <= ST_LOAD;
              ovf   <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // Output register: parts the chain from the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (emit) begin
      sorted_value <= $signed(stored[0].value);
      final_res    <= (count == CNT_W'(1));
      overflow     <= ovf;
    end
  end

  // Never more values in the row than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_COUNT))
    else $error("stored count above capacity");

  // In unload, no value is still waiting to enter the chain.
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UNLOAD) |-> !inj.valid)
    else $error("unload with a value still entering the chain");

  // Each emitted value comes from an occupied head cell.
  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    emit |-> stored[0].valid)
    else $error("emit from an empty head cell");

  // During unload the head cell holds no more than its right neighbor.
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UNLOAD) && stored[1].valid |->
      $signed(stored[0].value) <= $signed(stored[1].value))
    else $error("cell row out of order during unload");

  // After the final emit, the head cell is empty, the count is zero and loading resumes.
  a_block_end: assert property (@(posedge clk) disable iff (rst)
    emit && (count == CNT_W'(1)) |=> (state == ST_LOAD) && (count == '0)
      && !stored[0].valid)
    else $error("block did not close after its final result");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for integer_array_sorter_top (block sorter).
// Depends on ias_pkg and integer_array_sorter_top; keeps its own sorted-block predictor.

module testbench;

  localparam int CAPACITY  = ias_pkg::MAX_COUNT_DEF;
  localparam int DW        = ias_pkg::DATA_W;
  localparam int ITEM_GOAL = 280;

  localparam logic signed [DW-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] VAL_MIN = 32'sh8000_0000;

  // One expected result word.
  typedef struct packed {
    logic [DW-1:0] sorted_value;
    logic          final_res;
    logic          overflow;
  } sorted_word_t;

  // Collects the open block in ascending order and queues the sorted output
  // of each block as its last value is transferred.
  class sort_scoreboard;
    logic signed [DW-1:0] held[$];
    bit                   dropped;
    sorted_word_t         due[$];
    int                   errors;
    int                   checked;
    int                   overflow_blocks;
    int                   blocks;
    int                   biggest;

    function void note_item(logic signed [DW-1:0] v, logic is_last);
      int                   i;
      int                   n;
      logic signed [DW-1:0] t;
      sorted_word_t         w;
      if (held.size() < CAPACITY) begin
        held.push_back(v);
        i = held.size() - 1;
        // insertion step keeps held[] sorted, signed compare
        while (i > 0 && held[i] < held[i-1]) begin
          t         = held[i];
          held[i]   = held[i-1];
          held[i-1] = t;
          i--;
        end
      end else begin
        dropped = 1'b1;
      end
      if (is_last) begin
        n = held.size();
        for (i = 0; i < n; i++) begin
          w.sorted_value = held[i];
          w.final_res    = (i == n - 1);
          w.overflow     = dropped;
          due.push_back(w);
        end
        blocks++;
        if (dropped) overflow_blocks++;
        if (n > biggest) biggest = n;
        held.delete();
        dropped = 1'b0;
      end
    endfunction

    function void check_result(logic signed [DW-1:0] v, logic fin, logic ovf);
      sorted_word_t w;
      if (due.size() == 0) begin
        $display("%0t: unexpected result: sorted_value %0d final_res %0b overflow %0b",
                 $time, v, fin, ovf);
        errors++;
        return;
      end
      w = due.pop_front();
      checked++;
      if (w.sorted_value !== v) begin
        $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                 $time, $signed(w.sorted_value), v);
        errors++;
      end
      if (w.final_res !== fin) begin
        $display("%0t: final_res mismatch: expected %0b, actual %0b", $time, w.final_res, fin);
        errors++;
      end
      if (w.overflow !== ovf) begin
        $display("%0t: overflow mismatch: expected %0b, actual %0b", $time, w.overflow, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  // Block ports; every input is known from time zero.
  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_ready;
  logic signed [DW-1:0] value        = '0;
  logic                 last         = 1'b0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic signed [DW-1:0] sorted_value;
  logic                 final_res;
  logic                 overflow;

  sort_scoreboard sb = new;

  // While set, neither side inserts idle cycles.
  bit steady = 1'b0;
  int items_sent = 0;

  integer_array_sorter_top #(
    .MAX_COUNT(CAPACITY)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .value       (value),
    .last        (last),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .sorted_value(sorted_value),
    .final_res   (final_res),
    .overflow    (overflow)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Hard stop: the slowest legal run (280 one-value blocks, each waiting out
  // the full drain of the chain plus random stalls) stays far below this.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results still expected", sb.pending());
    $display("Verification failed");
    $finish;
  end

  // Result side: check each transfer against the oldest expectation and
  // withhold ready at random, with odds of about 13 in 100, outside the steady window.
  // Values are sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready)
        sb.check_result(sorted_value, final_res, overflow);
      result_ready <= steady || ($urandom_range(99) >= 13);
    end
  end

  // Mix of extremes, a narrow band that breeds duplicates, and full-width values.
  function automatic logic signed [DW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3, 4:    return $signed(DW'($urandom_range(16))) - 32'sd8;
      default: return $urandom;
    endcase
  endfunction

  // Drive one item and hold it until the transfer. Called at a rising edge;
  // returns at the edge of the transfer with valid still high, so the next
  // call (or the final drop) makes the only assignment in that step.
  task automatic send_item(logic signed [DW-1:0] v, logic is_last);
    int gap;
    gap = (!steady && $urandom_range(99) < 13) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    value      <= v;
    last       <= is_last;
    do @(posedge clk); while (!item_ready);
    sb.note_item(v, is_last);
    items_sent++;
  endtask

  task automatic send_block(int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  // Sender holds off until the sorter has emitted everything outstanding.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Directed blocks: lone max, lone min, mixed extremes around zero,
  // duplicates, equal minima, sorted and reverse-sorted runs.
  logic signed [DW-1:0] directed_vals [23] = '{
    VAL_MAX,
    VAL_MIN,
    32'sd0, -32'sd1, 32'sd1, VAL_MAX, VAL_MIN, -32'sd2,
    32'sd5, -32'sd5, 32'sd5, 32'sd5, -32'sd5,
    VAL_MIN, VAL_MIN,
    32'sd1, 32'sd2, 32'sd3, 32'sd4,
    32'sd4, 32'sd3, 32'sd2, 32'sd1
  };
  logic [22:0] directed_last = 23'b100_0100_0101_0000_1000_0011;

  initial begin
    int blk;
    int n;
    int r;
    int waited;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < 23; i++) send_item(directed_vals[i], directed_last[i]);
    item_valid <= 1'b0;
    @(posedge clk);
    wait_drained();

    // Random blocks: first a full store, then one that overflows (its last
    // value is dropped too); afterwards mostly small blocks.
    blk = 0;
    while (items_sent < ITEM_GOAL) begin
      if (blk == 0)
        n = CAPACITY;
      else if (blk == 1)
        n = CAPACITY + 3;
      else begin
        r = $urandom_range(99);
        if (r < 70)      n = $urandom_range(1, 6);
        else if (r < 95) n = $urandom_range(7, 20);
        else             n = $urandom_range(21, CAPACITY);
      end
      steady = (blk >= 4 && blk < 10);
      send_block(n);
      if (blk % 8 == 5) begin
        item_valid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      blk++;
    end
    item_valid <= 1'b0;
    steady = 1'b0;

    waited = 0;
    while (sb.pending() != 0 && waited < 50_000) begin
      @(posedge clk);
      waited++;
    end
    // any stray result after the last expected one shows up here
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end

    $display("Sent %0d values in %0d blocks (largest %0d, %0d over capacity)",
             items_sent, sb.blocks, sb.biggest, sb.overflow_blocks);
    $display("Checked %0d sorted results, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
